/* hdl/lidar_response_frame_parser_assert.svh */
// Assertion macros for the laser scanner reply parser checker.
// Included by the checker file; needs clk_i and rst_ni in scope.
`ifndef LIDAR_RESPONSE_FRAME_PARSER_ASSERT_SVH
`define LIDAR_RESPONSE_FRAME_PARSER_ASSERT_SVH

// Clocked assertion, held off while reset is asserted.
`define LRFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define LRFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/lrfp_pkg.sv */
// Shared types and constants of the laser scanner reply parser.
// No dependencies; used by the top level and its checker.
`default_nettype none

package lrfp_pkg;

  localparam logic [7:0] Sync0      = 8'hA5;
  localparam logic [7:0] Sync1      = 8'h5A;
  localparam logic [7:0] TypeScan   = 8'h05;
  localparam logic [7:0] TypeHealth = 8'h03;

  localparam logic [7:0] HealthOk   = 8'h00;
  localparam logic [7:0] HealthWarn = 8'h01;
  localparam logic [7:0] HealthErr  = 8'h02;

  localparam logic [2:0] DescLen   = 3'd7;
  localparam logic [2:0] ScanLen   = 3'd5;
  localparam logic [2:0] HealthLen = 3'd3;

  localparam logic [7:0] DecimationReset = 8'd12;

  // Parser modes
  localparam logic [1:0] ModeIdle   = 2'd0;
  localparam logic [1:0] ModeHealth = 2'd1;
  localparam logic [1:0] ModeScan   = 2'd2;

  // Result kinds
  localparam logic [2:0] KindStray   = 3'd0;
  localparam logic [2:0] KindUnident = 3'd1;
  localparam logic [2:0] KindOk      = 3'd2;
  localparam logic [2:0] KindWarn    = 3'd3;
  localparam logic [2:0] KindErr     = 3'd4;
  localparam logic [2:0] KindUnknown = 3'd5;
  localparam logic [2:0] KindScan    = 3'd6;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic        start_flag;
    logic [5:0]  quality;
    logic [14:0] angle_q6;
    logic [15:0] distance_q2;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

/* hdl/lidar_response_frame_parser.sv */
// Top level of the laser scanner reply parser: byte decode and result queue.
// Depends on lrfp_pkg.
`default_nettype none

// Reply stream parser for a laser range scanner. One byte word enters per
// cycle on the slave stream. A seven-byte descriptor opening A5 5A selects
// scan mode (five-byte frames) or health mode (one three-byte frame); any
// other descriptor type yields an "unidentified" result. Health frames give
// ok, warn, error (with its code in byte_value) or unknown status and drop
// back to idle. Only one scan frame in scan_decimation is decoded; a decoded
// frame that passes its check bits gives one sample, otherwise it is dropped.
// In idle mode, bytes that do not open a descriptor are echoed as stray.
// Rate: one input byte per cycle. The byte is decoded in the cycle it is
// accepted against the parser state registers, and its zero, one or two
// results are written into a four-entry output queue. The input is ready
// while the queue has two free entries, so a continuously draining consumer
// sees no stall; with the master side held, the queue fills and the input
// stalls. Results leave one per cycle from the queue head.
// scan_decimation is written through the cfg port; write it only while the block
// is idle, which the block itself does not enforce. A value of zero behaves like one.
module lidar_response_frame_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write: scan_decimation
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,
  // byte stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result stream out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [7:0] byte_value, [8] start_flag,
                                           // [14:9] quality, [29:15] angle_q6,
                                           // [45:30] distance_q2, [47:46] zero
  output logic [2:0]       m_axis_tuser,   // [2:0] kind
  output logic             m_axis_tlast    // last result of its input byte
);

  // Parser state
  logic [7:0] dec_q;
  logic [1:0] mode_q, mode_d;
  logic [2:0] fc_q, fc_d;
  logic [7:0] dc_q, dc_d;
  logic [7:0] fb_q [4];   // frame bytes 0..3; byte 4 of a scan frame is never stored
  logic [3:0] fb_we;

  // Result queue
  lrfp_pkg::res_t q_mem [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q;

  logic           in_acc, out_acc;
  logic [7:0]     b;
  logic [2:0]     fcc, fcn;
  logic [7:0]     v0, v1, v2, v3;
  logic           sync;
  logic [1:0]     n;
  lrfp_pkg::res_t r0, r1;
  logic [1:0]     wr_ptr_nx;

  assign cfg_ready_o   = 1'b1;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_acc       = m_axis_tvalid & m_axis_tready;
  assign s_axis_tready = (cnt_q <= 3'd2);
  assign b             = s_axis_tdata;

  // Slot for this byte; the count wraps after a full descriptor.
  assign fcc = (fc_q >= lrfp_pkg::DescLen) ? 3'd0 : fc_q;
  assign fcn = fcc + 3'd1;

  // Frame bytes as seen after this byte is stored.
  assign v0 = (fcc == 3'd0) ? b : fb_q[0];
  assign v1 = (fcc == 3'd1) ? b : fb_q[1];
  assign v2 = (fcc == 3'd2) ? b : fb_q[2];
  assign v3 = (fcc == 3'd3) ? b : fb_q[3];

  assign sync = (fcn >= 3'd2) && (v0 == lrfp_pkg::Sync0) && (v1 == lrfp_pkg::Sync1);

  always_comb begin
    mode_d = mode_q;
    fc_d   = fcn;
    dc_d   = dc_q;
    n      = 2'd0;
    r0     = '0;
    r1     = '0;
    for (int i = 0; i < 4; i++) begin
      fb_we[i] = (fcc == 3'(i));
    end

    if (sync) begin
      // Descriptor wins in every mode; collect all seven bytes.
      if (fcn == lrfp_pkg::DescLen) begin
        fc_d = 3'd0;
        if (v2 == lrfp_pkg::TypeScan) begin
          mode_d = lrfp_pkg::ModeScan;
        end else if (v2 == lrfp_pkg::TypeHealth) begin
          mode_d = lrfp_pkg::ModeHealth;
        end else begin
          r0.kind = lrfp_pkg::KindUnident;
          n       = 2'd1;
        end
      end
    end else if (mode_q == lrfp_pkg::ModeScan) begin
      if (fcn >= lrfp_pkg::ScanLen) begin
        fc_d = 3'd0;
        if ({1'b0, dc_q} + 9'd1 < {1'b0, dec_q}) begin
          dc_d = dc_q + 8'd1;
        end else begin
          dc_d = 8'd0;
          // check bits: byte1 bit 0 set, byte0 bits 0 and 1 differ
          if (v1[0] && (v0[0] != v0[1])) begin
            r0.kind        = lrfp_pkg::KindScan;
            r0.start_flag  = v0[0];
            r0.quality     = v0[7:2];
            r0.angle_q6    = {v2, v1[7:1]};
            r0.distance_q2 = {b, v3};
            n              = 2'd1;
          end
        end
      end
    end else if (mode_q == lrfp_pkg::ModeHealth) begin
      if (fcn >= lrfp_pkg::HealthLen) begin
        fc_d   = 3'd0;
        mode_d = lrfp_pkg::ModeIdle;
        n      = 2'd1;
        case (v0)
          lrfp_pkg::HealthOk:   r0.kind = lrfp_pkg::KindOk;
          lrfp_pkg::HealthWarn: r0.kind = lrfp_pkg::KindWarn;
          lrfp_pkg::HealthErr: begin
            r0.kind       = lrfp_pkg::KindErr;
            r0.byte_value = v1;
          end
          default:              r0.kind = lrfp_pkg::KindUnknown;
        endcase
      end
    end else begin
      // Idle: a lone A5 waits; anything else is echoed.
      if (fcn == 3'd1) begin
        if (b == lrfp_pkg::Sync0) begin
          fc_d = 3'd1;
        end else begin
          fc_d          = 3'd0;
          r0.kind       = lrfp_pkg::KindStray;
          r0.byte_value = b;
          n             = 2'd1;
        end
      end else begin
        // Held A5 not followed by 5A: echo it, then look at this byte afresh.
        r0.kind       = lrfp_pkg::KindStray;
        r0.byte_value = v0;
        n             = 2'd1;
        if (b == lrfp_pkg::Sync0) begin
          fc_d     = 3'd1;
          fb_we[0] = 1'b1;
        end else begin
          fc_d          = 3'd0;
          r1.kind       = lrfp_pkg::KindStray;
          r1.byte_value = b;
          n             = 2'd2;
        end
      end
    end

    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign wr_ptr_nx = wr_ptr_q + 2'd1;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q    <= lrfp_pkg::DecimationReset;
      mode_q   <= lrfp_pkg::ModeIdle;
      fc_q     <= 3'd0;
      dc_q     <= 8'd0;
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      if (cfg_valid_i) begin
        dec_q <= cfg_data_i;
      end
      if (in_acc) begin
        mode_q   <= mode_d;
        fc_q     <= fc_d;
        dc_q     <= dc_d;
        wr_ptr_q <= wr_ptr_q + n;
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + (in_acc ? {1'b0, n} : 3'd0) - {2'b0, out_acc};
    end
  end

  // Frame bytes and queued results; payload only
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < 4; i++) begin
        if (fb_we[i]) begin
          fb_q[i] <= b;
        end
      end
      if (n != 2'd0) begin
        q_mem[wr_ptr_q] <= r0;
      end
      if (n == 2'd2) begin
        q_mem[wr_ptr_nx] <= r1;
      end
    end
  end

  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign m_axis_tuser  = q_mem[rd_ptr_q].kind;
  assign m_axis_tlast  = q_mem[rd_ptr_q].last;
  assign m_axis_tdata  = {2'b00,
                          q_mem[rd_ptr_q].distance_q2,
                          q_mem[rd_ptr_q].angle_q6,
                          q_mem[rd_ptr_q].quality,
                          q_mem[rd_ptr_q].start_flag,
                          q_mem[rd_ptr_q].byte_value};

endmodule

`default_nettype wire

/* hdl/lrfp_checker.sv */
// Port-level checker for the laser scanner reply parser, bound to the top.
// Depends on lrfp_pkg and lidar_response_frame_parser_assert.svh.
`default_nettype none

`include "lidar_response_frame_parser_assert.svh"

module lrfp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // hold a stalled result word
  `LRFP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

  `LRFP_ASSERT(a_kind_range, m_axis_tvalid |-> m_axis_tuser <= lrfp_pkg::KindScan, "result kind out of range")

  // sample fields only on scan samples
  `LRFP_ASSERT(a_sample_zero, m_axis_tvalid && m_axis_tuser != lrfp_pkg::KindScan |-> m_axis_tdata[47:8] == 40'd0, "sample fields set on non-scan result")

  // byte value only on stray bytes and health errors
  `LRFP_ASSERT(a_byte_zero, m_axis_tvalid && m_axis_tuser != lrfp_pkg::KindStray && m_axis_tuser != lrfp_pkg::KindErr |-> m_axis_tdata[7:0] == 8'd0, "byte value set on wrong kind")

  `LRFP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid, "result valid right after reset")

endmodule

bind lidar_response_frame_parser lrfp_checker u_lrfp_checker (.*);

`default_nettype wire
